// ----- sv/lzt_pkg.sv -----
package lzt_pkg;

   // field widths fixed by the transaction format
   localparam int ACTION_W  = 3;
   localparam int NEURON_W  = 10;
   localparam int VALUE_W   = 32;
   localparam int NOW_W     = 32;
   localparam int TRACE_W   = 32;

   // configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_DECAY = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ZINT  = 2'd1;
   localparam logic [CSR_DATA_W-1:0]  DECAY_RESET = 16'd62339;
   localparam logic [CSR_DATA_W-1:0]  ZINT_RESET  = 16'd100;

   // action codes
   localparam logic [ACTION_W-1:0] ACT_GET = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_INC = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_ADD = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_SET = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_ALL = 3'd4;

   // decay arithmetic: unsigned Q0.16, widened to Q1.16 to hold 1.0 as 2^16
   localparam int DECAY_BITS = 16;
   localparam int EXP_BITS   = 16;
   localparam int ACC_W      = DECAY_BITS + 1;
   localparam int MUL_A_W    = 32;
   localparam int MUL_B_W    = ACC_W;
   localparam int PROD_W     = MUL_A_W + MUL_B_W;
   localparam int RND_W      = PROD_W - DECAY_BITS;
   localparam logic [ACC_W-1:0]  DECAY_ONE  = ACC_W'(1) << DECAY_BITS;
   localparam logic [PROD_W-1:0] DECAY_HALF = PROD_W'(1) << (DECAY_BITS - 1);

   // defaults for the top-level parameters
   localparam int NEURONS_DEFAULT   = 1024;
   localparam int FRAC_BITS_DEFAULT = 16;

endpackage

// ----- sv/lzt_req_if.sv -----
interface lzt_req_if;
   import lzt_pkg::*;

   logic                       valid;
   logic                       ready;
   logic        [ACTION_W-1:0] action;
   logic        [NEURON_W-1:0] neuron;
   logic signed [VALUE_W-1:0]  value;
   logic        [NOW_W-1:0]    now;

   modport source (output valid, action, neuron, value, now, input ready);
   modport sink   (input valid, action, neuron, value, now, output ready);

endinterface

// ----- sv/lzt_rsp_if.sv -----
interface lzt_rsp_if;
   import lzt_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [TRACE_W-1:0]  trace;

   modport source (output valid, trace, input ready);
   modport sink   (input valid, trace, output ready);

endinterface

// ----- sv/lazy_exponential_decay_trace.sv -----
// Flow: get/inc/add read the stores, then go straight to the result when no time has
//   passed or the entry is zeroed, else form the decay power first (one shared
//   32x17 multiplier, two uses per exponent bit, early exit on the top set bit).
//   Set, out-of-range and unused actions go straight to the result; set-all sweeps first.
// Throughput: one transaction at a time; the next is accepted once the last result is loaded.
// Reset: synchronous, active high; a clearing pass over every entry zeroes both stores.
module lazy_exponential_decay_trace #(
   parameter int NEURONS   = lzt_pkg::NEURONS_DEFAULT,
   parameter int FRAC_BITS = lzt_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   lzt_req_if.sink                            req_chan,
   lzt_rsp_if.source                          rsp_chan,
   input  logic                               csr_we,
   input  logic [lzt_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [lzt_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import lzt_pkg::*;

   localparam int AW = (NEURONS > 1) ? $clog2(NEURONS) : 1;
   localparam logic [AW-1:0] LAST_ADDR = AW'(NEURONS - 1);
   localparam logic [TRACE_W-1:0] INC_ONE = TRACE_W'(1) << FRAC_BITS;

   // sequencer states
   localparam logic [3:0] S_CLEAR = 4'd0;   // reset clearing pass
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_RD    = 4'd2;   // wait for registered store read
   localparam logic [3:0] S_EVAL  = 4'd3;   // elapsed ticks and early outs
   localparam logic [3:0] S_MACC  = 4'd4;   // acc = acc * base when exponent bit set
   localparam logic [3:0] S_MSQ   = 4'd5;   // base = base * base
   localparam logic [3:0] S_SCALE = 4'd6;   // trace = trace * acc, rounded to nearest, ties away from zero
   localparam logic [3:0] S_FIN   = 4'd7;   // add, write back, load result
   localparam logic [3:0] S_SWEEP = 4'd8;   // set-all sweep over the trace store

   logic [3:0]              state_ff, state_in;
   logic [AW-1:0]           sweep_ff, sweep_in;
   logic [CSR_DATA_W-1:0]   decay_ff, zint_ff;

   // latched transaction
   logic [ACTION_W-1:0]     action_ff;
   logic [NEURON_W-1:0]     neuron_ff;
   logic [VALUE_W-1:0]      value_ff;
   logic [NOW_W-1:0]        now_ff;
   logic                    ok_ff;

   // working registers
   logic [TRACE_W-1:0]      trace_ff, trace_in;
   logic [ACC_W-1:0]        acc_ff, acc_in;
   logic [DECAY_BITS-1:0]   base_ff, base_in;
   logic [EXP_BITS-1:0]     exp_ff, exp_in;

   // output register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [TRACE_W-1:0]      rsp_trace_ff, rsp_trace_in;

   // store ports
   logic                    trace_we, stamp_we;
   logic [AW-1:0]           waddr, raddr;
   logic [TRACE_W-1:0]      trace_wdata, trace_rdata;
   logic [NOW_W-1:0]        stamp_wdata, stamp_rdata;

   // shared multiplier
   logic [MUL_A_W-1:0]      mul_a;
   logic [MUL_B_W-1:0]      mul_b;
   logic [PROD_W-1:0]       prod, prod_rnd;
   logic [RND_W-1:0]        rnd;

   logic                    req_accept, out_free;
   logic [NOW_W-1:0]        elapsed;
   logic [TRACE_W-1:0]      mag, scaled, final_val, add_opd;
   logic [TRACE_W:0]        sum;
   logic [TRACE_W-1:0]      sat_sum;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.trace = rsp_trace_ff;

   // configuration registers; writes beyond the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         decay_ff <= DECAY_RESET;
         zint_ff  <= ZINT_RESET;
      end else if (csr_we) begin
         if (csr_index == CSR_DECAY) begin
            decay_ff <= csr_wdata;
         end else if (csr_index == CSR_ZINT) begin
            zint_ff <= csr_wdata;
         end
      end
   end

   // Multiplier operands: the power loop uses the low 17 bits of A, scaling uses all 32.
   always_comb begin
      mul_a = MUL_A_W'(acc_ff);
      mul_b = MUL_B_W'(base_ff);
      unique case (state_ff)
         S_MSQ: begin
            mul_a = MUL_A_W'(base_ff);
         end
         S_SCALE: begin
            mul_a = mag;
            mul_b = acc_ff;
         end
         default: begin
         end
      endcase
   end

   assign prod     = PROD_W'(mul_a) * PROD_W'(mul_b);
   assign prod_rnd = prod + DECAY_HALF;
   assign rnd      = prod_rnd[PROD_W-1:DECAY_BITS];

   // magnitude of the trace; the most negative value maps to 2^31 unsigned
   assign mag    = trace_ff[TRACE_W-1] ? (~trace_ff + TRACE_W'(1)) : trace_ff;
   assign scaled = trace_ff[TRACE_W-1] ? (~rnd[TRACE_W-1:0] + TRACE_W'(1))
                                       : rnd[TRACE_W-1:0];

   assign elapsed = now_ff - stamp_rdata;

   // saturating add of one or of the transaction value
   assign add_opd = (action_ff == ACT_INC) ? INC_ONE : value_ff;
   assign sum     = {trace_ff[TRACE_W-1], trace_ff} + {add_opd[TRACE_W-1], add_opd};
   always_comb begin
      if (sum[TRACE_W] != sum[TRACE_W-1]) begin
         sat_sum = sum[TRACE_W] ? {1'b1, {(TRACE_W-1){1'b0}}} : {1'b0, {(TRACE_W-1){1'b1}}};
      end else begin
         sat_sum = sum[TRACE_W-1:0];
      end
   end

   // result of the transaction; out-of-range neurons (set-all apart) and unused codes give zero
   always_comb begin
      final_val = '0;
      unique case (action_ff)
         ACT_GET: final_val = ok_ff ? trace_ff : '0;
         ACT_INC,
         ACT_ADD: final_val = ok_ff ? sat_sum : '0;
         ACT_SET: final_val = ok_ff ? value_ff : '0;
         ACT_ALL: final_val = value_ff;
         default: final_val = '0;
      endcase
   end

   // store port control
   assign raddr = AW'(neuron_ff);
   always_comb begin
      trace_we    = 1'b0;
      stamp_we    = 1'b0;
      waddr       = sweep_ff;
      trace_wdata = '0;
      stamp_wdata = '0;
      unique case (state_ff)
         S_CLEAR: begin
            trace_we = 1'b1;
            stamp_we = 1'b1;
         end
         S_SWEEP: begin
            trace_we    = 1'b1;
            trace_wdata = value_ff;
         end
         S_FIN: begin
            waddr       = AW'(neuron_ff);
            trace_wdata = final_val;
            stamp_wdata = now_ff;
            if (out_free && ok_ff) begin
               trace_we = (action_ff == ACT_GET) || (action_ff == ACT_INC) ||
                          (action_ff == ACT_ADD) || (action_ff == ACT_SET);
               stamp_we = (action_ff == ACT_GET) || (action_ff == ACT_INC) ||
                          (action_ff == ACT_ADD);
            end
         end
         default: begin
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      sweep_in     = sweep_ff;
      trace_in     = trace_ff;
      acc_in       = acc_ff;
      base_in      = base_ff;
      exp_in       = exp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_trace_in = rsp_trace_ff;
      unique case (state_ff)
         S_CLEAR: begin
            sweep_in = sweep_ff + AW'(1);
            if (sweep_ff == LAST_ADDR) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_accept) begin
               sweep_in = '0;
               unique case (req_chan.action)
                  ACT_GET,
                  ACT_INC,
                  ACT_ADD: begin
                     state_in = (32'(req_chan.neuron) < 32'(NEURONS)) ? S_RD : S_FIN;
                  end
                  ACT_ALL: state_in = S_SWEEP;
                  default: state_in = S_FIN;
               endcase
            end
         end
         S_RD: begin
            state_in = S_EVAL;
         end
         S_EVAL: begin
            // hold the entry when no tick has passed, zero it once the interval is reached
            trace_in = trace_rdata;
            acc_in   = DECAY_ONE;
            base_in  = decay_ff;
            exp_in   = elapsed[EXP_BITS-1:0];
            if (elapsed == '0) begin
               state_in = S_FIN;
            end else if (elapsed >= NOW_W'(zint_ff)) begin
               trace_in = '0;
               state_in = S_FIN;
            end else begin
               state_in = S_MACC;
            end
         end
         S_MACC: begin
            if (exp_ff[0]) begin
               acc_in = rnd[ACC_W-1:0];
            end
            // stop once no higher exponent bit is left
            state_in = (exp_ff[EXP_BITS-1:1] == '0) ? S_SCALE : S_MSQ;
         end
         S_MSQ: begin
            base_in  = rnd[DECAY_BITS-1:0];
            exp_in   = exp_ff >> 1;
            state_in = S_MACC;
         end
         S_SCALE: begin
            trace_in = scaled;
            state_in = S_FIN;
         end
         S_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_trace_in = final_val;
               state_in     = S_IDLE;
            end
         end
         S_SWEEP: begin
            sweep_in = sweep_ff + AW'(1);
            if (sweep_ff == LAST_ADDR) begin
               state_in = S_FIN;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         sweep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         action_ff <= req_chan.action;
         neuron_ff <= req_chan.neuron;
         value_ff  <= req_chan.value;
         now_ff    <= req_chan.now;
         ok_ff     <= (32'(req_chan.neuron) < 32'(NEURONS));
      end
      trace_ff     <= trace_in;
      acc_ff       <= acc_in;
      base_ff      <= base_in;
      exp_ff       <= exp_in;
      rsp_trace_ff <= rsp_trace_in;
   end

   lzt_ram #(
      .WIDTH (TRACE_W),
      .DEPTH (NEURONS)
   ) u_trace_ram (
      .clock (clock),
      .we    (trace_we),
      .waddr (waddr),
      .wdata (trace_wdata),
      .raddr (raddr),
      .rdata (trace_rdata)
   );

   lzt_ram #(
      .WIDTH (NOW_W),
      .DEPTH (NEURONS)
   ) u_stamp_ram (
      .clock (clock),
      .we    (stamp_we),
      .waddr (waddr),
      .wdata (stamp_wdata),
      .raddr (raddr),
      .rdata (stamp_rdata)
   );

   // the squaring step only runs while exponent bits remain
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MSQ) |-> (exp_ff != '0))
      else $error("squaring step with an empty exponent");

   // the decay power never rises above 1.0
   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_MACC) || (state_ff == S_MSQ) || (state_ff == S_SCALE))
         |-> (acc_ff <= DECAY_ONE))
      else $error("decay power above one");

   // a new result only comes out of the finishing step
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_FIN))
      else $error("result raised outside the finishing step");

   // an accepted transaction always leaves idle
   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff != S_IDLE))
      else $error("accepted transaction dropped");

endmodule

// ----- sv/lzt_ram.sv -----
module lzt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule
